// File: design/sefr_pkg.sv
// Shared types, codes and constants of the STX/ETX frame receiver.
package sefr_pkg;

   localparam int HEADER_BYTES = 5;
   // Start, id and the two length bytes are stored; the command byte closes the header.
   localparam int HDR_STORE = HEADER_BYTES - 1;
   localparam logic [15:0] MIN_FRAME_LENGTH = 16'(HEADER_BYTES + 1);

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_RECV    = 3'd1,
      ST_OK      = 3'd2,
      ST_BADHDR  = 3'd3,
      ST_BADEND  = 3'd4,
      ST_TIMEOUT = 3'd5
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_START_BYTE       = 3'd0,
      REG_DEVICE_ID        = 3'd1,
      REG_END_BYTE         = 3'd2,
      REG_TIMEOUT_TICKS    = 3'd3,
      REG_MAX_FRAME_LENGTH = 3'd4
   } reg_index_type;

   typedef enum logic {
      PH_HEADER = 1'b0,
      PH_DATA   = 1'b1
   } phase_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  device_id;
      logic [7:0]  end_byte;
      logic [15:0] timeout_ticks;
      logic [15:0] max_frame_length;
   } cfg_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  byte_value;
      logic [15:0] byte_position;
      logic        byte_valid;
      logic [15:0] frame_length;
      logic [7:0]  command;
   } result_type;

   // Handshake state passed from the result register back to the input register.
   typedef struct packed {
      logic out_free;
   } flow_type;

endpackage

// File: design/sefr_csr.sv
// Configuration registers of the frame receiver.
module sefr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sefr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sefr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sefr_pkg::cfg_type                 cfg
);
   import sefr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_START_BYTE:       cfg_in.start_byte       = csr_wdata[7:0];
            REG_DEVICE_ID:        cfg_in.device_id        = csr_wdata[7:0];
            REG_END_BYTE:         cfg_in.end_byte         = csr_wdata[7:0];
            REG_TIMEOUT_TICKS:    cfg_in.timeout_ticks    = csr_wdata[15:0];
            REG_MAX_FRAME_LENGTH: cfg_in.max_frame_length = csr_wdata[15:0];
            default:              cfg_in = cfg_ff;   // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte       <= 8'd2;
         cfg_ff.device_id        <= 8'd0;
         cfg_ff.end_byte         <= 8'd3;
         cfg_ff.timeout_ticks    <= 16'd100;
         cfg_ff.max_frame_length <= 16'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/sefr_in_reg.sv
// Input register: captures one request beat and hands it to the frame engine.
module sefr_in_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sefr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [sefr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  sefr_pkg::flow_type                 flow,
   output sefr_pkg::item_type                 item,
   output logic                               fire
);
   import sefr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Advance the held beat whenever the result register can take its result.
   assign fire       = valid_ff && flow.out_free;
   assign req_tready = !valid_ff || fire;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation <= op_type'(req_tuser[0]);
         item_ff.rx_byte   <= req_tdata[7:0];
      end
   end

   assign item = item_ff;

endmodule

// File: design/sefr_engine.sv
// Frame state and per-beat decision logic: header check, end check, timeout, overflow.
module sefr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  sefr_pkg::cfg_type    cfg,
   input  sefr_pkg::item_type   item,
   input  logic                 fire,
   output sefr_pkg::result_type result
);
   import sefr_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [15:0] count_ff,   count_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        timer_ff,   timer_in;
   logic [15:0] length_ff,  length_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  hdr_ff [HDR_STORE];
   logic [7:0]  hdr_in [HDR_STORE];

   logic [15:0] len_now;
   logic [7:0]  cmd_now;
   logic [15:0] elapsed_inc;
   logic [15:0] count_inc;
   logic [15:0] hdr_len;
   logic        hdr_ok;

   always_comb begin
      len_now     = (phase_ff == PH_DATA) ? length_ff  : 16'd0;
      cmd_now     = (phase_ff == PH_DATA) ? command_ff : 8'd0;
      elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : 16'(elapsed_ff + 16'd1);
      count_inc   = 16'(count_ff + 16'd1);
      hdr_len     = {hdr_ff[2], hdr_ff[3]};
      hdr_ok      = (hdr_ff[0] == cfg.start_byte) && (hdr_ff[1] == cfg.device_id) &&
                    (hdr_len >= MIN_FRAME_LENGTH);
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      timer_in   = timer_ff;
      length_in  = length_ff;
      command_in = command_ff;
      for (int i = 0; i < HDR_STORE; i++) begin
         hdr_in[i] = hdr_ff[i];
      end

      result.status        = ST_IDLE;
      result.byte_value    = 8'd0;
      result.byte_position = 16'd0;
      result.byte_valid    = 1'b0;
      result.frame_length  = 16'd0;
      result.command       = 8'd0;

      if (item.operation == OP_TICK) begin
         if (timer_ff) begin
            result.frame_length = len_now;
            result.command      = cmd_now;
            if (elapsed_inc >= cfg.timeout_ticks) begin
               // Timeout: drop the frame and re-arm.
               result.status = ST_TIMEOUT;
               phase_in      = PH_HEADER;
               count_in      = 16'd0;
               timer_in      = 1'b0;
               elapsed_in    = 16'd0;
            end else begin
               result.status = ST_RECV;
               elapsed_in    = elapsed_inc;
            end
         end
      end else if (count_ff >= cfg.max_frame_length) begin
         // Frame full: drop the byte, wait for the timeout.
         result.status       = timer_ff ? ST_RECV : ST_IDLE;
         result.frame_length = len_now;
         result.command      = cmd_now;
      end else begin
         count_in             = count_inc;
         result.byte_value    = item.rx_byte;
         result.byte_position = count_ff;
         result.byte_valid    = 1'b1;
         if (!timer_ff) begin
            timer_in   = 1'b1;
            elapsed_in = 16'd0;
         end
         if (phase_ff == PH_HEADER) begin
            if (count_ff < 16'(HDR_STORE)) begin
               hdr_in[count_ff[1:0]] = item.rx_byte;
               result.status         = ST_RECV;
            end else if (hdr_ok) begin
               result.status       = ST_RECV;
               result.frame_length = hdr_len;
               result.command      = item.rx_byte;
               phase_in            = PH_DATA;
               length_in           = hdr_len;
               command_in          = item.rx_byte;
            end else begin
               result.status = ST_BADHDR;
               phase_in      = PH_HEADER;
               count_in      = 16'd0;
               timer_in      = 1'b0;
               elapsed_in    = 16'd0;
            end
         end else begin
            result.frame_length = length_ff;
            result.command      = command_ff;
            if (count_inc == length_ff) begin
               // Last byte of the frame: check the end marker and re-arm.
               result.status = (item.rx_byte == cfg.end_byte) ? ST_OK : ST_BADEND;
               phase_in      = PH_HEADER;
               count_in      = 16'd0;
               timer_in      = 1'b0;
               elapsed_in    = 16'd0;
            end else begin
               result.status = ST_RECV;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         count_ff   <= 16'd0;
         elapsed_ff <= 16'd0;
         timer_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         timer_ff   <= timer_in;
      end
   end

   // Header bytes, length and command are always written before they are read.
   always_ff @(posedge clock) begin
      if (fire) begin
         length_ff  <= length_in;
         command_ff <= command_in;
         for (int i = 0; i < HDR_STORE; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

// File: design/sefr_out_reg.sv
// Result register: holds one response beat until the consumer takes it.
module sefr_out_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  sefr_pkg::result_type               result,
   output sefr_pkg::flow_type                 flow,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sefr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [sefr_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import sefr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign flow.out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.command, result_ff.frame_length,
                        result_ff.byte_position, result_ff.byte_value};
   assign rsp_tuser  = {result_ff.byte_valid, result_ff.status};

endmodule

// File: design/stx_etx_frame_receiver.sv
// Top level of the STX/ETX length-framed UART frame receiver.
//
//   channel | dir | beat contents (lowest bit first)
//   --------+-----+---------------------------------------------------------------
//   req_    | in  | tuser: operation(1); tdata: rx_byte(8)
//   rsp_    | out | tuser: status(3), byte_valid(1);
//           |     | tdata: byte_value(8), byte_position(16), frame_length(16), command(8)
//   csr_    | in  | write enable, register index(3), write data(16)
//
// Every request beat yields exactly one response beat, via the input register and then
// the result register. One beat is taken per cycle unless rsp_ stalls; they form a
// two-stage pipe, with the frame decision done in one pass between them.
// A stall on rsp_ holds the result register and then the input register; req_tready
// drops only when both are full.
// Reset (synchronous, active high) empties both registers, loads the register defaults
// and re-arms the receiver to wait for a start byte with the timer stopped.
module stx_etx_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = operation; tdata = rx_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sefr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [sefr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // response: tdata = byte_value, byte_position, frame_length, command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sefr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // response: tuser = status, byte_valid
   output logic [sefr_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   // configuration write port
   input  logic                               csr_we,
   input  logic [sefr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sefr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sefr_pkg::*;

   cfg_type    cfg;
   item_type   item;
   result_type result;
   flow_type   flow;
   logic       fire;

   // Hold the programmable frame markers, timeout and size limit.
   sefr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Capture the incoming beat; advance it when the result register has room.
   sefr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .flow       (flow),
      .item       (item),
      .fire       (fire)
   );

   // Decide the beat's outcome and update the frame state on advance.
   sefr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item),
      .fire   (fire),
      .result (result)
   );

   // Hold the response until the consumer takes it.
   sefr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .flow       (flow),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/sefr_checker.sv
// Port-level checks of the frame receiver and their binding to the top level.
module sefr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sefr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [sefr_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import sefr_pkg::*;

   logic [2:0] status;
   logic       byte_valid;

   assign status     = rsp_tuser[2:0];
   assign byte_valid = rsp_tuser[3];

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   a_dropped_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !byte_valid |-> rsp_tdata[23:0] == 24'd0)
      else $error("byte echo without an accepted byte");

   a_outcome_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_OK || status == ST_BADEND || status == ST_BADHDR)
      |-> byte_valid)
      else $error("frame outcome reported without a byte");

   a_idle_no_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_IDLE |-> rsp_tdata[47:24] == 24'd0 && !byte_valid)
      else $error("idle response carries frame data");

endmodule

bind stx_etx_frame_receiver sefr_checker u_sefr_checker (.*);

// File: tb/tb_stx_etx_frame_receiver.sv
// Self-checking testbench for the STX/ETX length-framed UART frame receiver.
module tb_stx_etx_frame_receiver;
   import sefr_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 64;
   // Receiver hold-off: long enough to fill both pipe registers and stall req_.
   localparam int HOLD_AT      = 300;
   localparam int HOLD_LEN     = 80;
   // Cycles to let pass after the last response before touching the registers.
   localparam int SETTLE       = 4;

   // One directed stimulus row; want is used only where typed is set.
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       typed;
      result_type want;
   } row_type;

   localparam result_type NO_CHECK = '0;
   localparam int DIR_ROWS  = 30;
   // Rows from here on run with the extreme register set written in between.
   localparam int DIR_SPLIT = 12;

   localparam row_type DIRECTED [0:DIR_ROWS-1] = '{
      // defaults: start 02, id 00, end 03, timeout 100, max 256
      '{OP_TICK, 8'h00, 1'b1, '{ST_IDLE, 8'h00, 16'd0, 1'b0, 16'd0, 8'h00}},
      '{OP_BYTE, 8'h02, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h06, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'hA5, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h03, 1'b1, '{ST_OK, 8'h03, 16'd5, 1'b1, 16'd6, 8'hA5}},
      // zero length in the header
      '{OP_BYTE, 8'h02, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h5A, 1'b1, '{ST_BADHDR, 8'h5A, 16'd4, 1'b1, 16'd0, 8'h00}},
      // start ff, id ff, end 00, timeout 2, max 6: timeout inside the header
      '{OP_BYTE, 8'hFF, 1'b0, NO_CHECK},
      '{OP_TICK, 8'hFF, 1'b0, NO_CHECK},
      '{OP_TICK, 8'h00, 1'b1, '{ST_TIMEOUT, 8'h00, 16'd0, 1'b0, 16'd0, 8'h00}},
      // header length 256 above the maximum: overflow, then timeout
      '{OP_BYTE, 8'hFF, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'hFF, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h01, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h77, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h12, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h34, 1'b1, '{ST_RECV, 8'h00, 16'd0, 1'b0, 16'd256, 8'h77}},
      '{OP_TICK, 8'h55, 1'b0, NO_CHECK},
      '{OP_TICK, 8'hAA, 1'b1, '{ST_TIMEOUT, 8'h00, 16'd0, 1'b0, 16'd256, 8'h77}},
      // shortest frame with a wrong end byte
      '{OP_BYTE, 8'hFF, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'hFF, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h00, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h06, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'hEE, 1'b0, NO_CHECK},
      '{OP_BYTE, 8'h01, 1'b1, '{ST_BADEND, 8'h01, 16'd5, 1'b1, 16'd6, 8'hEE}}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // rx_byte[7:0]
   logic [REQ_TUSER_W-1:0] req_tuser;   // operation[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // byte_value[7:0], byte_position[23:8], frame_length[39:24], command[47:40]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // status[2:0], byte_valid[3]
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   stx_etx_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Register copy and receiver state of the predictor.
   cfg_type     cfg;
   phase_type   rx_phase;
   logic [15:0] rx_count;
   logic [7:0]  hdr_store [0:HDR_STORE-1];
   logic [15:0] rx_length;
   logic [7:0]  rx_command;
   logic [15:0] tick_count;
   logic        timer_on;

   result_type  pending_results [$];
   item_type    stim_q [$];
   int unsigned errors;
   result_type  want_r, got_r;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("Test completed with failures");
      $finish;
   end

   function void clear_frame_state();
      rx_phase   = PH_HEADER;
      rx_count   = '0;
      for (int i = 0; i < HDR_STORE; i++) hdr_store[i] = '0;
      rx_length  = '0;
      rx_command = '0;
      tick_count = '0;
      timer_on   = 1'b0;
   endfunction

   // Advance the receiver by one byte or tick and return its response.
   function result_type receive_step(item_type it);
      result_type  r;
      logic [15:0] pos;
      logic [15:0] hdr_len;
      logic [15:0] cur_len;
      logic [7:0]  cur_cmd;
      r        = '0;
      r.status = ST_IDLE;
      cur_len  = (rx_phase == PH_DATA) ? rx_length : 16'd0;
      cur_cmd  = (rx_phase == PH_DATA) ? rx_command : 8'd0;

      if (it.operation == OP_TICK) begin
         if (!timer_on) return r;
         if (tick_count != 16'hFFFF) tick_count++;
         r.frame_length = cur_len;
         r.command      = cur_cmd;
         if (tick_count >= cfg.timeout_ticks) begin
            clear_frame_state();
            r.status = ST_TIMEOUT;
         end else begin
            r.status = ST_RECV;
         end
         return r;
      end

      // Frame full: drop the byte and wait for the timeout.
      if (rx_count >= cfg.max_frame_length) begin
         r.status       = timer_on ? ST_RECV : ST_IDLE;
         r.frame_length = cur_len;
         r.command      = cur_cmd;
         return r;
      end

      pos = rx_count;
      rx_count++;
      if (!timer_on) begin
         timer_on   = 1'b1;
         tick_count = '0;
      end
      r.byte_value    = it.rx_byte;
      r.byte_position = pos;
      r.byte_valid    = 1'b1;

      if (rx_phase == PH_HEADER) begin
         if (pos < HDR_STORE) begin
            hdr_store[pos[1:0]] = it.rx_byte;
            r.status = ST_RECV;
            return r;
         end
         // Command byte closes the header: check start, id and length together.
         hdr_len = {hdr_store[2], hdr_store[3]};
         if (hdr_store[0] == cfg.start_byte && hdr_store[1] == cfg.device_id &&
             hdr_len >= MIN_FRAME_LENGTH) begin
            rx_phase       = PH_DATA;
            rx_length      = hdr_len;
            rx_command     = it.rx_byte;
            r.status       = ST_RECV;
            r.frame_length = hdr_len;
            r.command      = it.rx_byte;
         end else begin
            clear_frame_state();
            r.status = ST_BADHDR;
         end
         return r;
      end

      r.frame_length = rx_length;
      r.command      = rx_command;
      if (rx_count == rx_length) begin
         r.status = (it.rx_byte == cfg.end_byte) ? ST_OK : ST_BADEND;
         clear_frame_state();
      end else begin
         r.status = ST_RECV;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random stimulus builders; each appends one sequence to stim_q.
   // ---------------------------------------------------------------------
   function void push_byte(logic [7:0] b);
      stim_q.push_back(item_type'{OP_BYTE, b});
   endfunction

   function void push_tick();
      stim_q.push_back(item_type'{OP_TICK, 8'($urandom)});
   endfunction

   // Mostly short frames; now and then a long one or one at the maximum.
   function logic [15:0] pick_length();
      int unsigned top;
      int unsigned roll;
      top  = (cfg.max_frame_length < 20) ? cfg.max_frame_length : 20;
      roll = $urandom_range(0, 39);
      if (roll == 0)
         return 16'($urandom_range(6, (cfg.max_frame_length < 300) ?
                                      cfg.max_frame_length : 300));
      if (roll == 1 && cfg.max_frame_length <= 64) return cfg.max_frame_length;
      return 16'($urandom_range(6, top));
   endfunction

   function void add_frame(logic [15:0] len, bit good_end);
      int unsigned ticks_left;
      ticks_left = (cfg.timeout_ticks - 1 < 2) ? cfg.timeout_ticks - 1 : 2;
      push_byte(cfg.start_byte);
      push_byte(cfg.device_id);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      push_byte(8'($urandom));
      for (int i = HEADER_BYTES; i < len - 1; i++) begin
         push_byte(8'($urandom));
         // Keep interleaved ticks below the timeout so the frame survives.
         if (ticks_left != 0 && $urandom_range(0, 15) == 0) begin
            push_tick();
            ticks_left--;
         end
      end
      push_byte(good_end ? cfg.end_byte : cfg.end_byte ^ 8'($urandom_range(1, 255)));
   endfunction

   function void add_bad_header();
      logic [7:0]  s, d;
      logic [15:0] len;
      s   = cfg.start_byte;
      d   = cfg.device_id;
      len = pick_length();
      case ($urandom_range(0, 2))
         0: begin
            s = s ^ 8'($urandom_range(1, 255));
         end
         1: begin
            d = d ^ 8'($urandom_range(1, 255));
         end
         default: begin
            len = 16'($urandom_range(0, HEADER_BYTES));
         end
      endcase
      push_byte(s);
      push_byte(d);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      push_byte(8'($urandom));
   endfunction

   function void add_noise();
      int unsigned n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: push_tick();
            1: push_byte(cfg.start_byte);
            default: push_byte(8'($urandom));
         endcase
      end
   endfunction

   // Header length above the maximum: fill the frame, then overrun it.
   function void add_oversize();
      logic [15:0] len;
      int unsigned extra;
      len   = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
              16'($urandom_range(cfg.max_frame_length + 1, 16'hFFFF));
      extra = $urandom_range(1, 3);
      push_byte(cfg.start_byte);
      push_byte(cfg.device_id);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      push_byte(8'($urandom));
      for (int i = HEADER_BYTES; i < cfg.max_frame_length + extra; i++)
         push_byte(8'($urandom));
   endfunction

   // Enough ticks to time out whatever is in progress.
   function void add_flush();
      for (int i = 0; i < cfg.timeout_ticks; i++) push_tick();
   endfunction

   function void build_phase_stimulus(int unsigned target);
      bit          dirty;
      bit          noisy;
      int unsigned kind;
      dirty = 1'b0;
      noisy = (cfg.timeout_ticks <= 64);
      stim_q.delete();
      while (stim_q.size() < target) begin
         kind = $urandom_range(0, 99);
         if (noisy && kind >= 85) begin
            add_noise();
            dirty = 1'b1;
         end else if (noisy && kind >= 78 && cfg.max_frame_length <= 64) begin
            add_oversize();
            dirty = 1'b1;
         end else begin
            // Well-formed sequences need an idle receiver: clear leftovers first.
            if (dirty) begin
               add_flush();
               dirty = 1'b0;
            end
            if (kind < 12)      add_bad_header();
            else if (kind < 20) add_frame(pick_length(), 1'b0);
            else                add_frame(pick_length(), 1'b1);
            if ($urandom_range(0, 3) == 0) push_tick();
         end
      end
      // Leave the receiver idle before the next register set.
      if (dirty) add_flush();
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offer one beat, hold it until taken, then queue its expected response.
   task automatic send_item(item_type it, bit typed, result_type want);
      result_type pred;
      req_tvalid <= 1'b1;
      req_tuser  <= it.operation;
      req_tdata  <= it.rx_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = receive_step(it);
      pending_results.push_back(typed ? want : pred);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_START_BYTE:       cfg.start_byte       = val[7:0];
         REG_DEVICE_ID:        cfg.device_id        = val[7:0];
         REG_END_BYTE:         cfg.end_byte         = val[7:0];
         REG_TIMEOUT_TICKS:    cfg.timeout_ticks    = val;
         REG_MAX_FRAME_LENGTH: cfg.max_frame_length = val;
         default: ;
      endcase
   endtask

   // Wait for every response, settle, then write the full register set.
   // Eight-bit registers get random upper bits that must be ignored.
   task automatic load_config(logic [7:0] s, logic [7:0] d, logic [7:0] e,
                              logic [15:0] tmo, logic [15:0] mx);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_START_BYTE,       {8'($urandom), s});
      write_reg(REG_DEVICE_ID,        {8'($urandom), d});
      write_reg(REG_END_BYTE,         {8'($urandom), e});
      write_reg(REG_TIMEOUT_TICKS,    tmo);
      write_reg(REG_MAX_FRAME_LENGTH, mx);
      csr_we <= 1'b0;
   endtask

   // Main sequence: reset, directed table, then random phases.
   initial begin
      int unsigned burst_left;
      int unsigned gap;
      bit          no_gaps;
      logic [15:0] tmo, mx;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      errors      = 0;
      cfg.start_byte       = 8'd2;
      cfg.device_id        = 8'd0;
      cfg.end_byte         = 8'd3;
      cfg.timeout_ticks    = 16'd100;
      cfg.max_frame_length = 16'd256;
      clear_frame_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table back to back.
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_SPLIT) begin
            req_tvalid <= 1'b0;
            load_config(8'hFF, 8'hFF, 8'h00, 16'd2, 16'd6);
         end
         send_item(item_type'{DIRECTED[i].op, DIRECTED[i].data},
                   DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         req_tvalid <= 1'b0;
         case (p)
            0: begin
               tmo = 16'd5;
               mx  = 16'd64;
            end
            1: begin
               tmo = 16'd1;
               mx  = 16'd6;
            end
            2: begin
               tmo = 16'hFFFF;
               mx  = 16'hFFFF;
            end
            default: begin
               tmo = 16'($urandom_range(1, 12));
               mx  = ($urandom_range(0, 3) == 0) ? 16'd256 : 16'($urandom_range(6, 40));
            end
         endcase
         case (p)
            1:       load_config(8'h00, 8'h00, 8'h00, tmo, mx);
            2:       load_config(8'hFF, 8'hFF, 8'hFF, tmo, mx);
            default: load_config(8'($urandom), 8'($urandom), 8'($urandom), tmo, mx);
         endcase
         build_phase_stimulus(PHASE_ITEMS);

         // Bursts with random gaps, except in phases run flat out.
         no_gaps    = (p % 3 == 1);
         burst_left = $urandom_range(1, 16);
         for (int i = 0; i < stim_q.size(); i++) begin
            send_item(stim_q[i], 1'b0, NO_CHECK);
            gap = 0;
            if (--burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if (!no_gaps) gap = $urandom_range(1, 8);
            end
            if (p == 3 && i == stim_q.size() / 2) begin
               // Pause mid-phase until every response is back.
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
            end else if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side: random ready pattern plus one long hold-off.
   initial begin
      int unsigned cycle_n;
      int unsigned hold_left;
      int unsigned pct;
      rsp_tready <= 1'b0;
      cycle_n   = 0;
      hold_left = 0;
      pct       = 100;
      forever begin
         @(posedge clock);
         cycle_n++;
         if (cycle_n % 50 == 0) begin
            case ($urandom_range(0, 3))
               0, 1:    pct = 100;
               2:       pct = 70;
               default: pct = 25;
            endcase
         end
         if (cycle_n == HOLD_AT) hold_left = HOLD_LEN;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) <= pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, name, want_v, got_v);
         errors++;
      end
   endtask

   // Compare every response beat with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with no expected result: tuser 0x%0h tdata 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want_r = pending_results.pop_front();
            got_r.status        = status_type'(rsp_tuser[2:0]);
            got_r.byte_valid    = rsp_tuser[3];
            got_r.byte_value    = rsp_tdata[7:0];
            got_r.byte_position = rsp_tdata[23:8];
            got_r.frame_length  = rsp_tdata[39:24];
            got_r.command       = rsp_tdata[47:40];
            check_field("status",        16'(want_r.status),     16'(got_r.status));
            check_field("byte_value",    16'(want_r.byte_value), 16'(got_r.byte_value));
            check_field("byte_position", want_r.byte_position,   got_r.byte_position);
            check_field("byte_valid",    16'(want_r.byte_valid), 16'(got_r.byte_valid));
            check_field("frame_length",  want_r.frame_length,    got_r.frame_length);
            check_field("command",       16'(want_r.command),    16'(got_r.command));
         end
      end
   end

endmodule

// File: filelist.f
design/sefr_pkg.sv
design/sefr_csr.sv
design/sefr_in_reg.sv
design/sefr_engine.sv
design/sefr_out_reg.sv
design/stx_etx_frame_receiver.sv
design/sefr_checker.sv
tb/tb_stx_etx_frame_receiver.sv
